// ----- hdl/f2c_pkg.sv -----
// Shared types and constants for the Frenet to Cartesian converter.
// No dependencies; every module of the block but f2c_map imports this package.
package f2c_pkg;

  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned UNIT_BITS = 30;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic [30:0]        entry_s;
    logic [30:0]        query_s;
    logic signed [31:0] query_d;
  } f2c_req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } f2c_rsp_t;

  // Round half toward plus infinity out of the Q34.30 accumulator scale, then saturate
  function automatic logic signed [31:0] f2c_finish(input logic signed [63:0] acc);
    logic signed [63:0] t;
    logic signed [33:0] q;
    t = acc + (64'sd1 <<< (UNIT_BITS - 1));
    q = t[63:30];
    if (q > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (q < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return q[31:0];
  endfunction

endpackage

// ----- hdl/f2c_map.sv -----
// Waypoint store: x, y and s arrays with one write and one registered read port.
// Depends on nothing but its parameters.
module f2c_map #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wx_i,
  input  logic signed [31:0] wy_i,
  input  logic [30:0]        ws_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic [30:0]        rs_o
);

  logic signed [31:0] mem_x [DEPTH];
  logic signed [31:0] mem_y [DEPTH];
  logic [30:0]        mem_s [DEPTH];

  // Write one waypoint
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
      mem_s[waddr_i] <= ws_i;
    end
  end

  // Registered read of all three arrays
  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
    rs_o <= mem_s[raddr_i];
  end

endmodule

// ----- hdl/f2c_udir.sv -----
// Unit direction of a segment vector in Q2.30: normalize, square root, divide.
// Iterative, one shift or one result bit per cycle; uses f2c_pkg.
module f2c_udir (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  output logic               done_o,
  output logic signed [31:0] ux_o,
  output logic signed [31:0] uy_o
);
  import f2c_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_NORM = 3'd1;
  localparam logic [2:0] U_SQA  = 3'd2;
  localparam logic [2:0] U_SQB  = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;
  localparam logic [2:0] U_DIV  = 3'd5;
  localparam logic [2:0] U_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [32:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [60:0] v_q;
  logic [61:0] r_q, bit_q;
  logic [30:0] len_q;
  logic [30:0] rem_q;
  logic [31:0] low_q;
  logic [31:0] quo_q;
  logic [4:0]  cnt_q;
  logic        sel_q;
  logic [31:0] qx_q, qy_q;

  logic [32:0] m;
  logic [29:0] mul_a;
  logic [59:0] sq;
  logic [61:0] t;
  logic [61:0] r_nx;
  logic [60:0] v_nx;
  logic [30:0] len_nx;
  logic [31:0] rem2;
  logic        qbit;
  logic [60:0] num;

  assign m     = (ax_q > ay_q) ? ax_q : ay_q;
  assign mul_a = (state_q == U_SQA) ? ax_q[29:0] : ay_q[29:0];
  assign sq    = {30'd0, mul_a} * {30'd0, mul_a};

  // One step of the restoring square root
  always_comb begin
    t = r_q + bit_q;
    if ({1'b0, v_q} >= t) begin
      v_nx = v_q - t[60:0];
      r_nx = (r_q >> 1) + bit_q;
    end else begin
      v_nx = v_q;
      r_nx = r_q >> 1;
    end
  end
  assign len_nx = r_nx[30:0];

  // One step of the restoring division
  assign rem2 = {rem_q, low_q[31]};
  assign qbit = (rem2 >= {1'b0, len_q});

  // Dividend for the next component, rounded by half the length
  always_comb begin
    logic [29:0] a;
    logic [30:0] l;
    a = (state_q == U_SQRT) ? ax_q[29:0] : ay_q[29:0];
    l = (state_q == U_SQRT) ? len_nx : len_q;
    num = ({31'd0, a} << UNIT_BITS) + {31'd0, l[30:1]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (start_i) state_d = U_NORM;
      U_NORM: begin
        if (m == '0) begin
          state_d = U_DONE;
        end else if (m[32:30] == '0 && m[29]) begin
          state_d = U_SQA;
        end
      end
      U_SQA:  state_d = U_SQB;
      U_SQB:  state_d = U_SQRT;
      U_SQRT: if (bit_q[0]) state_d = U_DIV;
      U_DIV:  if (cnt_q == 5'd31 && sel_q) state_d = U_DONE;
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          ax_q   <= dx_i[32] ? 33'(-dx_i) : 33'(dx_i);
          ay_q   <= dy_i[32] ? 33'(-dy_i) : 33'(dy_i);
          negx_q <= dx_i[32];
          negy_q <= dy_i[32];
        end
      end
      U_NORM: begin
        // Scale both alike until the larger lies in [2^29, 2^30)
        if (m == '0) begin
          qx_q   <= 32'd1 << UNIT_BITS;
          qy_q   <= '0;
          negx_q <= 1'b0;
          negy_q <= 1'b0;
        end else if (m[32:30] != '0) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else if (!m[29]) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      U_SQA: v_q <= {1'b0, sq};
      U_SQB: begin
        v_q   <= v_q + {1'b0, sq};
        r_q   <= '0;
        bit_q <= 62'd1 << 60;
      end
      U_SQRT: begin
        v_q   <= v_nx;
        r_q   <= r_nx;
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          len_q <= len_nx;
          rem_q <= {2'd0, num[60:32]};
          low_q <= num[31:0];
          cnt_q <= '0;
          sel_q <= 1'b0;
        end
      end
      U_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        quo_q <= {quo_q[30:0], qbit};
        low_q <= low_q << 1;
        rem_q <= qbit ? 31'(rem2 - {1'b0, len_q}) : rem2[30:0];
        if (cnt_q == 5'd31) begin
          if (!sel_q) begin
            qx_q  <= {quo_q[30:0], qbit};
            sel_q <= 1'b1;
            rem_q <= {2'd0, num[60:32]};
            low_q <= num[31:0];
          end else begin
            qy_q <= {quo_q[30:0], qbit};
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == U_DONE);
  assign ux_o   = negx_q ? -$signed(qx_q) : $signed(qx_q);
  assign uy_o   = negy_q ? -$signed(qy_q) : $signed(qy_q);

endmodule

// ----- hdl/f2c_proj.sv -----
// Projection: start point plus seg along the unit direction and d along its normal, rounded.
// One shared 32x32 multiplier over five steps; uses f2c_pkg.
module f2c_proj (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] sx_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] seg_i,
  input  logic signed [31:0] d_i,
  input  logic signed [31:0] ux_i,
  input  logic signed [31:0] uy_i,
  output logic               done_o,
  output f2c_pkg::f2c_rsp_t  rsp_o
);
  import f2c_pkg::*;

  logic               busy_q, done_q;
  logic [2:0]         step_q;
  logic signed [31:0] sy_q, seg_q, d_q, ux_q, uy_q;
  logic signed [63:0] prod_q, accx_q, accy_q;
  logic signed [31:0] mul_a, mul_b;

  // Pick operands for this step
  assign mul_a = (step_q == 3'd0 || step_q == 3'd2) ? seg_q : d_q;
  assign mul_b = (step_q == 3'd0 || step_q == 3'd3) ? ux_q : uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Multiply, then accumulate the registered product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      accx_q <= {{2{sx_i[31]}}, sx_i, 30'd0};
      sy_q   <= sy_i;
      seg_q  <= seg_i;
      d_q    <= d_i;
      ux_q   <= ux_i;
      uy_q   <= uy_i;
    end else if (busy_q) begin
      prod_q <= 64'(mul_a * mul_b);
      unique case (step_q)
        3'd1, 3'd2: accx_q <= accx_q + prod_q;
        3'd3:       accy_q <= {{2{sy_q[31]}}, sy_q, 30'd0} + prod_q;
        3'd4:       accy_q <= accy_q - prod_q;
        default: ;
      endcase
    end
  end

  assign done_o        = done_q;
  assign rsp_o.point_x = f2c_finish(accx_q);
  assign rsp_o.point_y = f2c_finish(accy_q);

endmodule

// ----- hdl/frenet_to_cartesian.sv -----
// Frenet to Cartesian converter over a closed-loop waypoint map.
// Instantiates f2c_map, f2c_udir and f2c_proj; uses f2c_pkg.
//
// A load request writes one waypoint and gives no result. A query request walks
// the stored arc lengths, up to the clamped waypoint count of them, through the
// map's single read port, reads the two segment ends, then the direction unit
// normalizes, squares, takes 31 square root steps and 2 x 32 divide steps, the
// projection multiplies and accumulates, and the result register takes the point.
// One request is worked on at a time; a new request is taken while a finished
// result still waits at the output.
module frenet_to_cartesian #(
  parameter int unsigned MAX_WAYPOINTS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [f2c_pkg::COUNT_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  f2c_pkg::f2c_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output f2c_pkg::f2c_rsp_t                out_rsp_o
);
  import f2c_pkg::*;

  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRD  = 4'd1;
  localparam logic [3:0] S_WCMP = 4'd2;
  localparam logic [3:0] S_RPRV = 4'd3;
  localparam logic [3:0] S_RNXT = 4'd4;
  localparam logic [3:0] S_CAPN = 4'd5;
  localparam logic [3:0] S_UDIR = 4'd6;
  localparam logic [3:0] S_PROJ = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q;
  logic [30:0]        s_q;
  logic signed [31:0] d_q;
  logic [AW-1:0]      last_q, j_q, prev_q, nxt;
  logic signed [31:0] px_q, py_q;
  logic [30:0]        ps_q;
  logic               out_valid_q;
  f2c_rsp_t           out_rsp_q;

  logic               accept, load_we, out_free;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rx, ry;
  logic [30:0]        rs;
  logic               udir_start, udir_done, proj_start, proj_done;
  logic signed [31:0] ux, uy;
  logic signed [31:0] seg;
  f2c_rsp_t           proj_rsp;
  int unsigned        n_clamp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_we    = accept && (in_req_i.func == FUNC_LOAD)
                      && (32'(in_req_i.entry_index) < MAX_WAYPOINTS);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp the waypoint count to the usable range
  always_comb begin
    n_clamp = 32'(count_q);
    if (n_clamp < 2) n_clamp = 2;
    if (n_clamp > MAX_WAYPOINTS) n_clamp = MAX_WAYPOINTS;
  end

  assign nxt = (prev_q == last_q) ? '0 : prev_q + 1'b1;

  // Read address for the current step
  always_comb begin
    unique case (state_q)
      S_WRD:   raddr = j_q;
      S_RPRV:  raddr = prev_q;
      default: raddr = nxt;
    endcase
  end

  f2c_map #(
    .DEPTH (MAX_WAYPOINTS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_req_i.entry_index)),
    .wx_i    (in_req_i.entry_x),
    .wy_i    (in_req_i.entry_y),
    .ws_i    (in_req_i.entry_s),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry),
    .rs_o    (rs)
  );

  assign udir_start = (state_q == S_CAPN);
  assign proj_start = (state_q == S_UDIR) && udir_done;
  assign seg        = $signed({1'b0, s_q}) - $signed({1'b0, ps_q});

  f2c_udir u_udir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (udir_start),
    .dx_i    (33'(rx) - 33'(px_q)),
    .dy_i    (33'(ry) - 33'(py_q)),
    .done_o  (udir_done),
    .ux_o    (ux),
    .uy_o    (uy)
  );

  f2c_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (proj_start),
    .sx_i    (px_q),
    .sy_i    (py_q),
    .seg_i   (seg),
    .d_i     (d_q),
    .ux_i    (ux),
    .uy_i    (uy),
    .done_o  (proj_done),
    .rsp_o   (proj_rsp)
  );

  // Sequence the walk, segment read and arithmetic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && in_req_i.func == FUNC_QUERY) state_d = S_WRD;
      S_WRD:  state_d = S_WCMP;
      S_WCMP: begin
        if (s_q > rs && j_q != last_q) begin
          state_d = S_WRD;
        end else begin
          state_d = S_RPRV;
        end
      end
      S_RPRV: state_d = S_RNXT;
      S_RNXT: state_d = S_CAPN;
      S_CAPN: state_d = S_UDIR;
      S_UDIR: if (udir_done) state_d = S_PROJ;
      S_PROJ: if (proj_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= COUNT_W'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      // Hold the result until taken
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Query payload and walk registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          s_q    <= in_req_i.query_s;
          d_q    <= in_req_i.query_d;
          last_q <= AW'(n_clamp - 1);
          j_q    <= '0;
          prev_q <= '0;
        end
      end
      S_WCMP: begin
        if (s_q > rs) begin
          prev_q <= j_q;
          j_q    <= j_q + 1'b1;
        end
      end
      S_RNXT: begin
        px_q <= rx;
        py_q <= ry;
        ps_q <= rs;
      end
      S_OUT: if (out_free) out_rsp_q <= proj_rsp;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- tb/sv/f2c_checker.sv -----
`timescale 1ns / 1ps
// Checker for frenet_to_cartesian: mirrors the waypoint map and count, predicts
// each query's point and compares it with the block's output. Uses f2c_pkg.
module f2c_checker
  import f2c_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  f2c_req_t             in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  f2c_rsp_t             out_rsp_i,
  output int                   fail_count_o,
  output int                   points_checked_o,
  output int                   pending_o
);

  logic signed [63:0] way_x [256];
  logic signed [63:0] way_y [256];
  logic signed [63:0] way_s [256];
  logic [COUNT_W-1:0] track_len;
  f2c_rsp_t           expected_points [$];
  f2c_rsp_t           want;

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Drop 30 fraction bits rounding half up, then clamp to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
    logic signed [63:0] q;
    q = (acc + (64'sd1 <<< 29)) >>> 30;
    if (q > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  // Walk the map for the segment, build the unit direction and project
  function automatic f2c_rsp_t project_point(input logic [30:0] qs,
                                             input logic signed [31:0] qd);
    int n, lo, hi;
    logic signed [63:0] s, d, dx, dy, ux, uy, seg;
    logic [63:0] ax, ay, m, len, qx, qy;
    f2c_rsp_t p;
    n = track_len;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    s = {33'd0, qs};
    d = qd;
    lo = -1;
    while (lo < n - 1 && s > way_s[lo + 1]) lo++;
    if (lo < 0) lo = 0;
    hi = lo + 1;
    if (hi >= n) hi = 0;
    dx = way_x[hi] - way_x[lo];
    dy = way_y[hi] - way_y[lo];
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    m = (ax > ay) ? ax : ay;
    if (m == 0) begin
      ux = 64'sd1 <<< 30;
      uy = 0;
    end else begin
      while (m >= (64'd1 << 30)) begin
        ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
        ax = ax << 1; ay = ay << 1; m = m << 1;
      end
      len = root_floor(ax * ax + ay * ay);
      qx = ((ax << 30) + len / 2) / len;
      qy = ((ay << 30) + len / 2) / len;
      ux = (dx < 0) ? -$signed(qx) : $signed(qx);
      uy = (dy < 0) ? -$signed(qy) : $signed(qy);
    end
    seg = s - way_s[lo];
    p.point_x = round_sat((way_x[lo] <<< 30) + seg * ux + d * uy);
    p.point_y = round_sat((way_y[lo] <<< 30) + seg * uy - d * ux);
    return p;
  endfunction

  // Check results first, then track config and requests of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_len = 2;
      for (int i = 0; i < 256; i++) begin
        way_x[i] = 0; way_y[i] = 0; way_s[i] = 0;
      end
      expected_points.delete();
      fail_count_o = 0;
      points_checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d", $time,
                   out_rsp_i.point_x, out_rsp_i.point_y);
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          points_checked_o++;
          if (out_rsp_i.point_x !== want.point_x) begin
            $display("%0t: point_x expected %0d got %0d", $time,
                     want.point_x, out_rsp_i.point_x);
            fail_count_o++;
          end
          if (out_rsp_i.point_y !== want.point_y) begin
            $display("%0t: point_y expected %0d got %0d", $time,
                     want.point_y, out_rsp_i.point_y);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) track_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.func == FUNC_LOAD) begin
          way_x[in_req_i.entry_index] = in_req_i.entry_x;
          way_y[in_req_i.entry_index] = in_req_i.entry_y;
          way_s[in_req_i.entry_index] = {33'd0, in_req_i.entry_s};
        end else begin
          expected_points = {expected_points,
                             project_point(in_req_i.query_s, in_req_i.query_d)};
        end
      end
    end
  end

  assign pending_o = expected_points.size();

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Top of the frenet_to_cartesian testbench: clock, reset, request and stall
// stimulus, and the verdict. Depends on f2c_pkg, the block and f2c_checker.
module tb;
  import f2c_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  f2c_req_t           in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  f2c_rsp_t           out_rsp;
  int                 fail_count, points_checked, pending;
  int                 requests_sent, settings_used;
  bit                 calm = 1'b0;
  logic [30:0]        trk_s [256];
  int                 trk_m;
  bit                 loaded [256];

  always #5 clk_i = ~clk_i;

  frenet_to_cartesian DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  f2c_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .fail_count_o     (fail_count),
    .points_checked_o (points_checked),
    .pending_o        (pending)
  );

  // Hold one request until accepted, with an optional gap before it
  task automatic send(input f2c_req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    requests_sent++;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load(input int idx, input logic signed [31:0] x,
                      input logic signed [31:0] y, input logic [31:0] s);
    f2c_req_t r;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(f2c_req_t)-1:0];
    r.func = FUNC_LOAD;
    r.entry_index = 8'(idx);
    r.entry_x = x;
    r.entry_y = y;
    r.entry_s = s[30:0];
    loaded[idx] = 1'b1;
    trk_s[idx] = s[30:0];
    send(r);
  endtask

  task automatic query(input logic [31:0] s, input logic signed [31:0] d);
    f2c_req_t r;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(f2c_req_t)-1:0];
    r.func = FUNC_QUERY;
    r.query_s = s[30:0];
    r.query_d = d;
    send(r);
  endtask

  // Drain all points, then let the block go idle before a register write
  task automatic settle;
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Load a fresh track over waypoints 0..m-1
  task automatic load_track(input int m);
    int style;
    logic [63:0] s;
    logic signed [31:0] x, y;
    style = $urandom_range(0, 5);
    s = 64'($urandom_range(0, 4 << 16));
    x = (style == 0) ? $urandom : $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    y = (style == 0) ? $urandom : $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    for (int i = 0; i < m; i++) begin
      if (style == 0) begin
        x = $urandom;
        y = $urandom;
        s = (64'h7FFF_FFFF / m) * i + $urandom_range(0, 1000);
        if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
      end else if (i > 0) begin
        if (!(style == 1 && $urandom_range(0, 2) == 0)) begin
          x = x + $signed($urandom_range(0, 60 << 16)) - (30 << 16);
          y = y + $signed($urandom_range(0, 60 << 16)) - (30 << 16);
        end
        s = s + $urandom_range(0, 20 << 16);
      end
      load(i, x, y, s[31:0]);
    end
    trk_m = m;
  endtask

  task automatic random_query;
    logic [31:0] top_s;
    logic [31:0] s;
    logic signed [31:0] d;
    top_s = {1'b0, trk_s[trk_m - 1]} + (3 << 16);
    if (top_s > 32'h7FFF_FFFF) top_s = 32'h7FFF_FFFF;
    case ($urandom_range(0, 9))
      0:       s = $urandom & 32'h7FFF_FFFF;
      1:       s = {1'b0, trk_s[$urandom_range(0, trk_m - 1)]};
      default: s = $urandom_range(0, top_s);
    endcase
    case ($urandom_range(0, 9))
      8:       d = $urandom;
      9:       d = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: d = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
    query(s, d);
  endtask

  // Random stall bursts on the result side
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n, m, phase, nq;
    logic [COUNT_W-1:0] plan [7];
    plan = '{9'd1, 9'd0, 9'd3, 9'd256, 9'd511, 9'd257, 9'd2};
    requests_sent = 0;
    settings_used = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: default count of two, edge values and corner cases
    load(0, 0, 0, 1 << 16);
    load(1, 3 << 16, 4 << 16, 6 << 16);
    query(0, 0);
    query(1 << 16, 2 << 16);
    query(3 << 16, -(2 << 16));
    query(6 << 16, 0);
    query(32'h7FFF_FFFF, 32'sh7FFF_FFFF);
    query(32'h7FFF_FFFF, 32'sh8000_0000);
    load(1, 0, 0, 2 << 16);
    query(1 << 16, 5 << 16);
    query(5 << 16, 1 << 16);
    load(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    load(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h7FFF_FFFF);
    query(0, 32'sh8000_0000);
    query(32'h4000_0000, 32'sh7FFF_FFFF);
    query(32'h7FFF_FFFF, 0);
    load(255, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h7FFF_FFFF);
    load(0, -(5 << 16), 7 << 16, 0);
    load(1, -(5 << 16), 7 << 16, 0);
    query(0, 3 << 16);
    query(10 << 16, -(3 << 16));

    // Random phases across count settings
    phase = 0;
    while (requests_sent < 1400) begin
      n = (phase < 7) ? plan[phase] :
          ($urandom_range(0, 7) == 0 ? $urandom_range(0, 511) : $urandom_range(2, 24));
      m = (n < 2) ? 2 : (n > 256 ? 256 : n);
      write_count(COUNT_W'(n));
      if (requests_sent > 1200) calm = 1'b1;
      else calm = (phase % 3 == 2);
      if (m <= 40 || !loaded[m - 1]) load_track(m);
      else trk_m = m;
      for (int i = 0; i < m; i++) if (!loaded[i]) load(i, $urandom, $urandom, $urandom);
      nq = (m > 40) ? 20 : $urandom_range(60, 120);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 6) == 0) load($urandom_range(0, 255), $urandom, $urandom, $urandom);
        else random_query();
      end
      phase++;
    end

    settle();
    repeat (700) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d converted points", requests_sent,
             points_checked);
    $display("Covered %0d waypoint-count settings, including out-of-range counts",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/f2c_pkg.sv
hdl/f2c_map.sv
hdl/f2c_udir.sv
hdl/f2c_proj.sv
hdl/frenet_to_cartesian.sv
tb/sv/f2c_checker.sv
tb/sv/tb.sv
